/* sv/gf13_pkg.sv */
// gf13_pkg: shared types, operation codes and constants for the GF(2^13) unit
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package gf13_pkg;

  localparam int FIELD_BITS = 13;

  typedef logic [FIELD_BITS-1:0] elem_t;

  // operation codes carried by the action field
  localparam logic [2:0] ACT_ADD  = 3'd0;
  localparam logic [2:0] ACT_MUL  = 3'd1;
  localparam logic [2:0] ACT_SQR  = 3'd2;
  localparam logic [2:0] ACT_SQRT = 3'd3;
  localparam logic [2:0] ACT_INV  = 3'd4;

  // reset value of the reduction polynomial (x^13 + x^4 + x^3 + x + 1)
  localparam elem_t POLY_RESET = elem_t'(27);

  // multiply steps per operation
  localparam int SQRT_STEPS = 12;
  localparam int INV_STEPS  = 16;
  localparam int CNT_W      = $clog2(INV_STEPS);

  localparam logic [CNT_W-1:0] ONE_LAST  = '0;
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);
  localparam logic [CNT_W-1:0] INV_LAST  = CNT_W'(INV_STEPS - 1);

  // inverse chain steps that use or load the saved power
  localparam logic [CNT_W-1:0] INV_K_P2  = CNT_W'(0);
  localparam logic [CNT_W-1:0] INV_K_P6  = CNT_W'(2);
  localparam logic [CNT_W-1:0] INV_K_P7  = CNT_W'(3);
  localparam logic [CNT_W-1:0] INV_K_P63 = CNT_W'(7);
  localparam logic [CNT_W-1:0] INV_K_R   = CNT_W'(14);

  // second multiplier operand select
  typedef enum logic [1:0] {
    SEL_CUR  = 2'd0,
    SEL_KEEP = 2'd1,
    SEL_OPA  = 2'd2,
    SEL_OPB  = 2'd3
  } ysel_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // control from sequencer to datapath
  typedef struct packed {
    logic  busy;
    logic  step;
    ysel_t y_sel;
    logic  keep_load;
    logic  done;
  } ctrl_t;

endpackage

`default_nettype wire

/* sv/gf13_mul.sv */
// gf13_mul: shared shift-and-reduce field multiplier, one product per cycle
// depends on gf13_pkg
`timescale 1ns / 1ps
`default_nettype none

module gf13_mul import gf13_pkg::*; (
  input  elem_t x,
  input  elem_t y,
  input  elem_t poly,
  output elem_t prod
);

  // multiplicand doubled per multiplier bit, reduced when x^12 shifts out
  always_comb begin
    elem_t t;
    elem_t acc;
    t   = x;
    acc = '0;
    for (int i = 0; i < FIELD_BITS; i++) begin
      if (y[i]) begin
        acc = acc ^ t;
      end
      t = {t[FIELD_BITS-2:0], 1'b0} ^ (t[FIELD_BITS-1] ? poly : elem_t'(0));
    end
    prod = acc;
  end

endmodule

`default_nettype wire

/* sv/gf13_ctrl.sv */
// gf13_ctrl: sequencer that steps the shared multiplier through each operation
// depends on gf13_pkg
`timescale 1ns / 1ps
`default_nettype none

module gf13_ctrl import gf13_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [2:0] action,
  output ctrl_t      ctl
);

  state_t           state, state_next;
  logic [2:0]       op;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] last_idx;
  logic             last;
  logic             needs_steps;

  // operations that go through the multiplier
  assign needs_steps = (action == ACT_MUL) || (action == ACT_SQR) ||
                       (action == ACT_SQRT) || (action == ACT_INV);

  // final step index of the running operation
  always_comb begin
    case (op)
      ACT_SQRT: last_idx = SQRT_LAST;
      ACT_INV:  last_idx = INV_LAST;
      default:  last_idx = ONE_LAST;
    endcase
  end

  assign last = (count == last_idx);

  // operand select and saved-power load along the chains, plus status
  always_comb begin
    ctl.busy      = (state == ST_RUN);
    ctl.step      = (state == ST_RUN);
    ctl.done      = (state == ST_DONE);
    ctl.y_sel     = SEL_CUR;
    ctl.keep_load = 1'b0;
    case (op)
      ACT_MUL: ctl.y_sel = SEL_OPB;
      ACT_INV: begin
        if (count == INV_K_P6 || count == INV_K_P63 || count == INV_K_R) begin
          ctl.y_sel = SEL_KEEP;
        end else if (count == INV_K_P7) begin
          ctl.y_sel = SEL_OPA;
        end
        ctl.keep_load = (count == INV_K_P2) || (count == INV_K_P7) ||
                        (count == INV_K_P63);
      end
      default: ctl.y_sel = SEL_CUR;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE, ST_DONE: begin
        if (accept) begin
          state_next = needs_steps ? ST_RUN : ST_DONE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_RUN: begin
        if (last) begin
          state_next = ST_DONE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state, operation and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= ACT_ADD;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        op    <= action;
        count <= '0;
      end else if (state == ST_RUN) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // result strobe lasts one cycle unless a new add or undefined code follows at once
  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && last) |=> ctl.done)
    else $error("last step not followed by result strobe");

  a_busy_after_step_accept: assert property (@(posedge clk) disable iff (rst)
    (accept && needs_steps) |=> ctl.busy)
    else $error("stepped operation accepted but sequencer not running");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (count <= last_idx))
    else $error("step counter ran past the last step");

  a_no_accept_running: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> !accept)
    else $error("word accepted while the multiplier sequence runs");

endmodule

`default_nettype wire

/* sv/gf2_13_arithmetic_unit.sv */
// gf2_13_arithmetic_unit: top level with operand registers, polynomial register
// depends on gf13_pkg, gf13_mul and gf13_ctrl
`timescale 1ns / 1ps
`default_nettype none

// GF(2^13) arithmetic unit, polynomial basis.
// Input: a word is taken at a rising edge with start high and busy low; action
// selects add, multiply, square, square root or inverse on operand_a/operand_b.
// Output: result is shown for one cycle with done high; the receiver cannot
// stall, so each result must be taken in that cycle.
// Configuration: cfg_data is written to the reduction polynomial (low 13 bits,
// x^13 implied) at an edge with cfg_valid and cfg_ready high; ready while the
// unit is not stepping.
// Add and undefined codes need no multiply steps and go to the done state directly;
// multiply, square, square root and inverse first run their multiply chains. One
// shared field multiplier does one multiply per cycle while the unit is stepping.
// A new word may be accepted in the done cycle, but not while a chain runs.
// Reset (synchronous, rst high) returns to idle and loads polynomial 0x001B.
module gf2_13_arithmetic_unit import gf13_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] action,
  input  elem_t      operand_a,
  input  elem_t      operand_b,
  output logic       done,
  output elem_t      result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  elem_t      cfg_data
);

  ctrl_t ctl;
  logic  accept;
  elem_t poly;
  elem_t cur;
  elem_t opa;
  elem_t opb;
  elem_t keep;
  elem_t y;
  elem_t prod;
  elem_t load_val;

  assign accept    = start && !ctl.busy;
  assign busy      = ctl.busy;
  assign cfg_ready = !ctl.busy;

  // sequencer
  gf13_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .action (action),
    .ctl    (ctl)
  );

  // second multiplier operand
  always_comb begin
    case (ctl.y_sel)
      SEL_KEEP: y = keep;
      SEL_OPA:  y = opa;
      SEL_OPB:  y = opb;
      default:  y = cur;
    endcase
  end

  // shared multiplier
  gf13_mul u_mul (
    .x    (cur),
    .y    (y),
    .poly (poly),
    .prod (prod)
  );

  // value loaded into the accumulator on accept
  always_comb begin
    case (action)
      ACT_ADD:  load_val = operand_a ^ operand_b;
      ACT_MUL, ACT_SQR, ACT_SQRT, ACT_INV: load_val = operand_a;
      default:  load_val = '0;
    endcase
  end

  // polynomial register
  always_ff @(posedge clk) begin
    if (rst) begin
      poly <= POLY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      poly <= cfg_data;
    end
  end

  // operand, accumulator and saved-power registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= load_val;
      opa <= operand_a;
      opb <= operand_b;
    end else if (ctl.step) begin
      cur <= prod;
      if (ctl.keep_load) begin
        keep <= prod;
      end
    end
  end

  assign done   = ctl.done;
  assign result = cur;

endmodule

`default_nettype wire

/* tb/testbench.sv */
// testbench: self-checking bench for the GF(2^13) arithmetic unit
// drives words and polynomial settings, checks each result against a field model
// depends on gf13_pkg and gf2_13_arithmetic_unit
`timescale 1ns / 1ps

module testbench;
  import gf13_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int WORDS_PER_PHASE = 300;
  localparam int POLY_PHASES = 5;
  localparam int IDLE_PCT = 27;
  localparam int RSVD_PCT = 5;
  // longest chain is inverse
  localparam int DRAIN_CYCLES = 20;
  localparam int QUIET_PHASE = 2;

  // action codes with no operation behind them
  localparam logic [2:0] ACT_RSVD_LO  = 3'd5;
  localparam logic [2:0] ACT_RSVD_MID = 3'd6;
  localparam logic [2:0] ACT_RSVD_HI  = 3'd7;

  localparam elem_t ELEM_ZERO = '0;
  localparam elem_t ELEM_ONE = elem_t'(1);
  localparam elem_t ELEM_ALL = '1;
  localparam elem_t ELEM_TOP = elem_t'(1) << (FIELD_BITS - 1);

  typedef struct {
    logic [2:0] act;
    elem_t      a;
    elem_t      b;
    bit         fixed;
    elem_t      want;
  } stim_row_t;

  typedef struct {
    logic [2:0] act;
    elem_t      a;
    elem_t      b;
    elem_t      want;
  } due_word_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [2:0] action;
  elem_t      operand_a;
  elem_t      operand_b;
  logic       done;
  elem_t      result;
  logic       cfg_valid;
  logic       cfg_ready;
  elem_t      cfg_data;

  due_word_t due_results[$];
  elem_t     poly_now = POLY_RESET;
  bit        gaps_on = 1'b1;
  int        cycle_count = 0;
  int        mismatches = 0;
  int        results_checked = 0;
  int        words_sent = 0;
  int        polys_written = 0;
  int        action_seen[8];

  gf2_13_arithmetic_unit dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .action   (action),
    .operand_a(operand_a),
    .operand_b(operand_b),
    .done     (done),
    .result   (result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // shift-and-add multiply, reduced whenever the x^12 bit shifts out
  function automatic elem_t field_mul(input elem_t a, input elem_t b);
    elem_t acc;
    elem_t t;
    acc = '0;
    t = a;
    for (int i = 0; i < FIELD_BITS; i++) begin
      if (b[i]) acc ^= t;
      t = t[FIELD_BITS-1] ? ((t << 1) ^ poly_now) : (t << 1);
    end
    return acc;
  endfunction

  // a^(2^n) by repeated squaring
  function automatic elem_t field_sqr_n(input elem_t a, input int n);
    elem_t r;
    r = a;
    for (int i = 0; i < n; i++) r = field_mul(r, r);
    return r;
  endfunction

  // addition chain to a^8190; zero stays zero
  function automatic elem_t field_inv(input elem_t a);
    elem_t p2;
    elem_t p4;
    elem_t p7;
    elem_t p63;
    elem_t r;
    p2 = field_mul(a, a);
    p4 = field_mul(p2, p2);
    p7 = field_mul(field_mul(p4, p2), a);
    p63 = field_mul(field_sqr_n(p7, 3), p7);
    r = field_mul(field_sqr_n(p63, 6), p63);
    return field_mul(r, r);
  endfunction

  function automatic elem_t field_result(input logic [2:0] act, input elem_t a, input elem_t b);
    case (act)
      ACT_ADD:  return a ^ b;
      ACT_MUL:  return field_mul(a, b);
      ACT_SQR:  return field_mul(a, a);
      ACT_SQRT: return field_sqr_n(a, SQRT_STEPS);
      ACT_INV:  return field_inv(a);
      default:  return '0;
    endcase
  endfunction

  // operands weighted towards zero, one, all ones and single bits
  function automatic elem_t rand_elem();
    case ($urandom_range(9))
      0:       return ELEM_ZERO;
      1:       return ELEM_ONE;
      2:       return ELEM_ALL;
      3:       return elem_t'(1) << $urandom_range(FIELD_BITS - 1);
      default: return elem_t'($urandom_range(0, 8191));
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // offer one word until it is taken, with random idle cycles
  task automatic send_word(input logic [2:0] act, input elem_t a, input elem_t b,
                           input bit fixed, input elem_t want);
    due_word_t w;
    bit taken;
    action <= act;
    operand_a <= a;
    operand_b <= b;
    taken = 1'b0;
    while (!taken) begin
      start <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
      @(posedge clk);
      taken = start && !busy;
    end
    w.act = act;
    w.a = a;
    w.b = b;
    w.want = fixed ? want : field_result(act, a, b);
    due_results.push_back(w);
    words_sent++;
    action_seen[act]++;
  endtask

  task automatic random_word();
    logic [2:0] act;
    if ($urandom_range(99) < RSVD_PCT) begin
      act = 3'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
    end else begin
      act = 3'($urandom_range(ACT_ADD, ACT_INV));
    end
    send_word(act, rand_elem(), rand_elem(), 1'b0, ELEM_ZERO);
  endtask

  // polynomial write, only once every result has come back
  task automatic write_poly(input elem_t p);
    bit taken;
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    cfg_data <= p;
    taken = 1'b0;
    while (!taken) begin
      cfg_valid <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
      @(posedge clk);
      taken = cfg_valid && cfg_ready;
    end
    cfg_valid <= 1'b0;
    poly_now = p;
    polys_written++;
  endtask

  // result checker: every strobe must match the oldest outstanding word
  always @(posedge clk) begin : check_results
    due_word_t w;
    if (!rst && done === 1'b1) begin
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result %h with no word outstanding", result));
      end else begin
        w = due_results.pop_front();
        results_checked++;
        if (result !== w.want) begin
          report_mismatch($sformatf("action %0d a %h b %h poly %h: result %h, want %h",
                                    w.act, w.a, w.b, poly_now, result, w.want));
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("testbench failed");
    $finish;
  end

  initial begin : run
    stim_row_t rows[$];
    elem_t poly_plan[POLY_PHASES];
    rst = 1'b1;
    start = 1'b0;
    action = ACT_ADD;
    operand_a = '0;
    operand_b = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;

    // directed words under the reset polynomial
    rows.push_back('{ACT_ADD, ELEM_ZERO, ELEM_ZERO, 1'b1, ELEM_ZERO});
    rows.push_back('{ACT_ADD, ELEM_ALL, ELEM_ZERO, 1'b1, ELEM_ALL});
    rows.push_back('{ACT_ADD, ELEM_ALL, ELEM_ALL, 1'b1, ELEM_ZERO});
    rows.push_back('{ACT_ADD, 13'h1555, 13'h0AAA, 1'b1, ELEM_ALL});
    rows.push_back('{ACT_MUL, ELEM_ZERO, ELEM_ALL, 1'b1, ELEM_ZERO});
    rows.push_back('{ACT_MUL, ELEM_ONE, ELEM_ALL, 1'b1, ELEM_ALL});
    rows.push_back('{ACT_MUL, ELEM_ALL, ELEM_ONE, 1'b1, ELEM_ALL});
    // x^12 times x wraps to the polynomial itself
    rows.push_back('{ACT_MUL, ELEM_TOP, 13'h0002, 1'b1, POLY_RESET});
    rows.push_back('{ACT_MUL, ELEM_ALL, ELEM_ALL, 1'b0, ELEM_ZERO});
    rows.push_back('{ACT_MUL, ELEM_TOP, ELEM_TOP, 1'b0, ELEM_ZERO});
    rows.push_back('{ACT_SQR, ELEM_ZERO, ELEM_ALL, 1'b1, ELEM_ZERO});
    rows.push_back('{ACT_SQR, ELEM_ONE, ELEM_ZERO, 1'b1, ELEM_ONE});
    rows.push_back('{ACT_SQR, ELEM_ALL, ELEM_ALL, 1'b0, ELEM_ZERO});
    rows.push_back('{ACT_SQRT, ELEM_ZERO, ELEM_ALL, 1'b1, ELEM_ZERO});
    rows.push_back('{ACT_SQRT, ELEM_ONE, ELEM_ZERO, 1'b1, ELEM_ONE});
    rows.push_back('{ACT_SQRT, ELEM_ALL, ELEM_ZERO, 1'b0, ELEM_ZERO});
    rows.push_back('{ACT_SQRT, 13'h0002, ELEM_ALL, 1'b0, ELEM_ZERO});
    // inverse of zero gives zero
    rows.push_back('{ACT_INV, ELEM_ZERO, ELEM_ALL, 1'b1, ELEM_ZERO});
    rows.push_back('{ACT_INV, ELEM_ONE, ELEM_ZERO, 1'b1, ELEM_ONE});
    rows.push_back('{ACT_INV, 13'h0002, ELEM_ZERO, 1'b0, ELEM_ZERO});
    rows.push_back('{ACT_INV, ELEM_ALL, ELEM_ALL, 1'b0, ELEM_ZERO});
    // codes with no operation give zero
    rows.push_back('{ACT_RSVD_LO, ELEM_ALL, ELEM_ALL, 1'b1, ELEM_ZERO});
    rows.push_back('{ACT_RSVD_MID, 13'h1234, ELEM_ONE, 1'b1, ELEM_ZERO});
    rows.push_back('{ACT_RSVD_HI, ELEM_ONE, ELEM_ALL, 1'b1, ELEM_ZERO});

    // zero and all ones are reducible, still fully determined
    poly_plan[0] = ELEM_ZERO;
    poly_plan[1] = ELEM_ALL;
    poly_plan[2] = elem_t'($urandom_range(0, 8191));
    poly_plan[3] = POLY_RESET;
    poly_plan[4] = elem_t'($urandom_range(0, 8191));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_word(rows[i].act, rows[i].a, rows[i].b, rows[i].fixed, rows[i].want);

    // random words, one polynomial per phase, one phase with no idling
    for (int p = 0; p < POLY_PHASES; p++) begin
      write_poly(poly_plan[p]);
      gaps_on = (p != QUIET_PHASE);
      repeat (WORDS_PER_PHASE) random_word();
    end

    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d words: add %0d, mul %0d, sqr %0d, sqrt %0d, inv %0d, undefined %0d",
             words_sent, action_seen[ACT_ADD], action_seen[ACT_MUL], action_seen[ACT_SQR],
             action_seen[ACT_SQRT], action_seen[ACT_INV],
             action_seen[ACT_RSVD_LO] + action_seen[ACT_RSVD_MID] + action_seen[ACT_RSVD_HI]);
    $display("%0d polynomial writes incl. zero and all ones; %0d results checked, %0d mismatches",
             polys_written, results_checked, mismatches);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
